[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WFA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed in the same cycle");

// The consequent holds in the cycle after the antecedent.
`define WFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed in the following cycle");

`endif

[hw/rtl/wfa_pkg.sv]
// Types, codes and defaults shared by the worst-fit allocator modules.
`timescale 1ns / 1ps

package wfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int REQ_W    = 16;
	localparam int BIDX_W   = 4;
	localparam int GIDX_W   = 4;
	localparam int GSIZE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

	typedef enum logic [1:0] {
		CMT_TAKE,
		CMT_FREE,
		CMT_APPEND
	} commit_kind_t;

	// Request record that walks the row of cells, one cell per cycle.
	typedef struct packed {
		logic             valid;
		logic             cmd;
		logic             found;
		logic [REQ_W-1:0] req;
		logic [BIDX_W-1:0] bidx;
	} scan_ctl_t;

	// State update broadcast to all cells once a scan has finished.
	typedef struct packed {
		logic         valid;
		commit_kind_t kind;
	} commit_t;

endpackage

[hw/rtl/wfa_cell.sv]
// One table entry of the allocator: holds a block and judges the passing request.
`timescale 1ns / 1ps

module wfa_cell #(
	parameter int CELL_IDX  = 0,
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = wfa_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wfa_pkg::scan_ctl_t    ctl_in,
	input  logic [IDX_W-1:0]      best_idx_in,
	input  logic [SIZE_BITS-1:0]  best_size_in,
	output wfa_pkg::scan_ctl_t    ctl_out,
	output logic [IDX_W-1:0]      best_idx_out,
	output logic [SIZE_BITS-1:0]  best_size_out,
	input  wfa_pkg::commit_t      cmt,
	input  logic [IDX_W-1:0]      cmt_idx,
	input  logic [SIZE_BITS-1:0]  cmt_size
);

	localparam int CMP_W = (SIZE_BITS > wfa_pkg::REQ_W) ? SIZE_BITS : wfa_pkg::REQ_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [SIZE_BITS-1:0] size_q;
	logic                 free_q;
	logic                 used_q;

	wfa_pkg::scan_ctl_t   ctl_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic fits;
	logic hit_alloc;
	logic hit_rel;
	logic hit;
	logic cmt_here;

	always_comb begin
		fits      = CMP_W'(size_q) >= CMP_W'(ctl_in.req);
		hit_alloc = ctl_in.cmd == wfa_pkg::CMD_ALLOC && used_q && free_q && fits &&
			(!ctl_in.found || size_q > best_size_in);
		hit_rel   = ctl_in.cmd == wfa_pkg::CMD_RELEASE && used_q && !free_q &&
			32'(ctl_in.bidx) == 32'(CELL_IDX);
		hit       = ctl_in.valid && (hit_alloc || hit_rel);
		cmt_here  = cmt.valid && cmt_idx == MY_IDX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= ctl_in.valid;
			ctl_q.cmd   <= ctl_in.cmd;
			ctl_q.found <= ctl_in.found | hit;
			ctl_q.req   <= ctl_in.req;
			ctl_q.bidx  <= ctl_in.bidx;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			best_idx_q  <= MY_IDX;
			best_size_q <= size_q;
		end else begin
			best_idx_q  <= best_idx_in;
			best_size_q <= best_size_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b0;
			used_q <= 1'b0;
		end else if (cmt_here) begin
			case (cmt.kind)
				wfa_pkg::CMT_TAKE: begin
					free_q <= 1'b0;
				end
				wfa_pkg::CMT_FREE: begin
					free_q <= 1'b1;
				end
				wfa_pkg::CMT_APPEND: begin
					free_q <= 1'b0;
					used_q <= 1'b1;
				end
				default: begin
					free_q <= free_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmt_here && cmt.kind == wfa_pkg::CMT_APPEND) begin
			size_q <= cmt_size;
		end
	end

	assign ctl_out       = ctl_q;
	assign best_idx_out  = best_idx_q;
	assign best_size_out = best_size_q;

endmodule

[hw/rtl/worst_fit_block_allocator_top.sv]
// Worst-fit block allocator: a row of table cells scanned by a travelling request.
//
// Input channel s_axis: tuser carries the command (allocate or release), tdata carries
// the requested size and the block index to release. Output channel m_axis: tdata
// carries the granted index and size, tuser carries the status. Every input item
// produces exactly one output item.
// An accepted item enters a register, then walks the row of MAX_BLOCKS cells, one cell
// per cycle, and its result is registered behind the last cell. A new item is accepted
// once the previous one has left the row, so the block does not take a new item before
// it is through with the last one.
// The table update of an item is applied to the cells as its result is registered.
// Reset empties the table: no block exists and the next allocate appends at index 0.
// If the receiver stalls, a finished result waits in the output register and a second
// one in a skid register; input is also refused while that skid register is full.
`timescale 1ns / 1ps

module worst_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = wfa_pkg::SIZE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [15:0] request_size, [19:16] block_index, [23:20] zero
	input  logic [wfa_pkg::S_DATA_W-1:0] s_axis_tdata,
	// [0] command
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [3:0] granted_index, [19:4] granted_size, [23:20] zero
	output logic [wfa_pkg::M_DATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic [wfa_pkg::STATUS_W-1:0] m_axis_tuser
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_BITS) - 64'd1;
	localparam int PAD_W = wfa_pkg::M_DATA_W - wfa_pkg::GIDX_W - wfa_pkg::GSIZE_W;

	wfa_pkg::scan_ctl_t   ctl [MAX_BLOCKS+1];
	logic [IDX_W-1:0]     bidx_c [MAX_BLOCKS+1];
	logic [SIZE_BITS-1:0] bsize_c [MAX_BLOCKS+1];

	wfa_pkg::scan_ctl_t   inj_q;
	logic                 busy_q;
	logic [CNT_W-1:0]     count_q;

	wfa_pkg::commit_t     cmt;
	logic [IDX_W-1:0]     cmt_idx;
	logic [SIZE_BITS-1:0] cmt_size;

	logic [wfa_pkg::GIDX_W-1:0]   res_idx;
	logic [wfa_pkg::GSIZE_W-1:0]  res_size;
	logic [wfa_pkg::STATUS_W-1:0] res_st;

	logic                         out_valid_q;
	logic [wfa_pkg::M_DATA_W-1:0] out_data_q;
	logic [wfa_pkg::STATUS_W-1:0] out_user_q;
	logic                         skid_valid_q;
	logic [wfa_pkg::M_DATA_W-1:0] skid_data_q;
	logic [wfa_pkg::STATUS_W-1:0] skid_user_q;

	logic                         accept;
	logic                         done;
	logic                         wide;
	logic                         has_room;
	logic [31:0]                  best_idx_ext;
	logic [31:0]                  best_size_ext;
	logic [31:0]                  count_ext;
	logic [wfa_pkg::M_DATA_W-1:0] res_data;
	logic                         out_free;
	logic                         load_skid_to_out;
	logic                         load_res_to_out;
	logic                         load_res_to_skid;

	assign s_axis_tready = !busy_q && !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q <= '0;
		end else begin
			inj_q.valid <= accept;
			if (accept) begin
				inj_q.cmd   <= s_axis_tuser;
				inj_q.found <= 1'b0;
				inj_q.req   <= s_axis_tdata[wfa_pkg::REQ_W-1:0];
				inj_q.bidx  <= s_axis_tdata[wfa_pkg::REQ_W +: wfa_pkg::BIDX_W];
			end
		end
	end

	assign ctl[0]     = inj_q;
	assign bidx_c[0]  = '0;
	assign bsize_c[0] = '0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		wfa_cell #(
			.CELL_IDX  (g),
			.IDX_W     (IDX_W),
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl_in        (ctl[g]),
			.best_idx_in   (bidx_c[g]),
			.best_size_in  (bsize_c[g]),
			.ctl_out       (ctl[g+1]),
			.best_idx_out  (bidx_c[g+1]),
			.best_size_out (bsize_c[g+1]),
			.cmt           (cmt),
			.cmt_idx       (cmt_idx),
			.cmt_size      (cmt_size)
		);
	end

	// Decision taken when the request leaves the last cell.
	always_comb begin
		done          = ctl[MAX_BLOCKS].valid;
		wide          = 64'(ctl[MAX_BLOCKS].req) > SIZE_MASK;
		has_room      = count_q < CNT_W'(MAX_BLOCKS);
		best_idx_ext  = 32'(bidx_c[MAX_BLOCKS]);
		best_size_ext = 32'(bsize_c[MAX_BLOCKS]);
		count_ext     = 32'(count_q);

		cmt.valid = 1'b0;
		cmt.kind  = wfa_pkg::CMT_TAKE;
		cmt_idx   = bidx_c[MAX_BLOCKS];
		cmt_size  = SIZE_BITS'(ctl[MAX_BLOCKS].req);
		res_idx   = '0;
		res_size  = '0;
		res_st    = wfa_pkg::ST_FULL;

		if (ctl[MAX_BLOCKS].cmd == wfa_pkg::CMD_RELEASE) begin
			res_idx = ctl[MAX_BLOCKS].bidx;
			if (ctl[MAX_BLOCKS].found) begin
				cmt.valid = done;
				cmt.kind  = wfa_pkg::CMT_FREE;
				res_size  = best_size_ext[wfa_pkg::GSIZE_W-1:0];
				res_st    = wfa_pkg::ST_OK;
			end else begin
				res_st = wfa_pkg::ST_BAD_RELEASE;
			end
		end else if (wide) begin
			res_st = wfa_pkg::ST_FULL;
		end else if (ctl[MAX_BLOCKS].found) begin
			cmt.valid = done;
			cmt.kind  = wfa_pkg::CMT_TAKE;
			res_idx   = best_idx_ext[wfa_pkg::GIDX_W-1:0];
			res_size  = best_size_ext[wfa_pkg::GSIZE_W-1:0];
			res_st    = wfa_pkg::ST_OK;
		end else if (has_room) begin
			cmt.valid = done;
			cmt.kind  = wfa_pkg::CMT_APPEND;
			cmt_idx   = count_ext[IDX_W-1:0];
			res_idx   = count_ext[wfa_pkg::GIDX_W-1:0];
			res_size  = ctl[MAX_BLOCKS].req;
			res_st    = wfa_pkg::ST_OK;
		end
		res_data = {PAD_W'(0), res_size, res_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (cmt.valid && cmt.kind == wfa_pkg::CMT_APPEND) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		out_free         = !out_valid_q || m_axis_tready;
		load_skid_to_out = out_free && skid_valid_q;
		load_res_to_out  = out_free && !skid_valid_q && done;
		load_res_to_skid = !out_free && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q || done;
			end
			if (load_skid_to_out) begin
				skid_valid_q <= 1'b0;
			end else if (load_res_to_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_skid_to_out) begin
			out_data_q <= skid_data_q;
			out_user_q <= skid_user_q;
		end else if (load_res_to_out) begin
			out_data_q <= res_data;
			out_user_q <= res_st;
		end
		if (load_res_to_skid) begin
			skid_data_q <= res_data;
			skid_user_q <= res_st;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[hw/rtl/wfa_checker.sv]
// Port-level checks of the worst-fit allocator, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wfa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [wfa_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [wfa_pkg::STATUS_W-1:0] m_axis_tuser
);

	logic in_acc;
	logic out_full;
	logic out_bad;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_full = m_axis_tvalid && m_axis_tuser == wfa_pkg::ST_FULL;
	assign out_bad  = m_axis_tvalid && m_axis_tuser == wfa_pkg::ST_BAD_RELEASE;

	// An accepted item occupies the cell row, so no second item follows at once.
	`WFA_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
	`WFA_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`WFA_ASSERT_SAME(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
	// A failed allocation carries neither an index nor a size.
	`WFA_ASSERT_SAME(a_full_zero, out_full, m_axis_tdata == '0)
	`WFA_ASSERT_SAME(a_bad_size_zero, out_bad, m_axis_tdata[19:4] == 16'd0)

endmodule

bind worst_fit_block_allocator_top wfa_checker u_wfa_checker (.*);

[dv/tb_worst_fit_block_allocator_top.sv]
// Self-checking testbench for the worst-fit block allocator with a built-in grant predictor.
`timescale 1ns / 1ps

module tb_worst_fit_block_allocator_top;
	import wfa_pkg::*;

	localparam int NUM_BLOCKS   = MAX_BLOCKS_DEF;
	localparam int RANDOM_ITEMS = 1750;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  size;
		logic [BIDX_W-1:0] idx;
	} alloc_cmd_t;

	typedef struct {
		alloc_cmd_t op;
		int         gap;
		bit         drain;
	} queued_cmd_t;

	typedef struct packed {
		logic [GIDX_W-1:0]   idx;
		logic [GSIZE_W-1:0]  size;
		logic [STATUS_W-1:0] status;
	} grant_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic                  s_axis_tuser = CMD_ALLOC;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	queued_cmd_t alloc_cmds[$];
	grant_t      grants_due[$];
	int          mismatches = 0;

	// Predicted allocator state, owned by the monitor.
	logic [REQ_W-1:0] blk_size [NUM_BLOCKS];
	bit               blk_free [NUM_BLOCKS];
	int               blk_count = 0;

	int gap_waited = 0;
	int in_flight = 0;
	int ready_hold = 0;
	int grants_seen = 0;
	int queued_total = 0;

	worst_fit_block_allocator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic grant_t worst_fit_grant(input alloc_cmd_t op);
		grant_t g;
		bit     found;
		int     best;
		g = '{idx: op.idx, size: '0, status: ST_BAD_RELEASE};
		found = 1'b0;
		best = 0;
		if (op.cmd == CMD_RELEASE) begin
			if (int'(op.idx) < blk_count && !blk_free[op.idx]) begin
				blk_free[op.idx] = 1'b1;
				g.size = blk_size[op.idx];
				g.status = ST_OK;
			end
			return g;
		end
		// Largest free block that fits; strict compare keeps the lowest index on a tie.
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_size[i] >= op.size &&
					(!found || blk_size[i] > blk_size[best])) begin
				found = 1'b1;
				best = i;
			end
		end
		if (found) begin
			blk_free[best] = 1'b0;
			g = '{idx: GIDX_W'(best), size: blk_size[best], status: ST_OK};
		end else if (blk_count < NUM_BLOCKS) begin
			blk_size[blk_count] = op.size;
			blk_free[blk_count] = 1'b0;
			g = '{idx: GIDX_W'(blk_count), size: op.size, status: ST_OK};
			blk_count++;
		end else begin
			g = '{idx: '0, size: '0, status: ST_FULL};
		end
		return g;
	endfunction

	// Driver: presents queued items, honoring each item's gap and drain request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= CMD_ALLOC;
			gap_waited = 0;
			in_flight = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				in_flight++;
			if (m_axis_tvalid && m_axis_tready)
				in_flight--;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (alloc_cmds.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (gap_waited < alloc_cmds[0].gap) begin
					gap_waited++;
					s_axis_tvalid <= 1'b0;
				end else if (alloc_cmds[0].drain && in_flight != 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					queued_cmd_t q;
					q = alloc_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= q.op.cmd;
					s_axis_tdata <= {4'd0, q.op.idx, q.op.size};
					gap_waited = 0;
				end
			end
		end
	end

	// Monitor: checks each result item, then predicts for the item accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold = 0;
			blk_count = 0;
			for (int i = 0; i < NUM_BLOCKS; i++)
				blk_free[i] = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (grants_due.size() == 0) begin
					$error("result item with no expectation: tdata=%h tuser=%h",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					grant_t want;
					want = grants_due.pop_front();
					if (m_axis_tdata[3:0] !== want.idx) begin
						$error("granted_index: expected %0d, actual %0d", want.idx,
							m_axis_tdata[3:0]);
						mismatches++;
					end
					if (m_axis_tdata[19:4] !== want.size) begin
						$error("granted_size: expected %0d, actual %0d", want.size,
							m_axis_tdata[19:4]);
						mismatches++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							m_axis_tuser);
						mismatches++;
					end
				end
				grants_seen++;
				// Every third stretch of results runs with the receiver always ready.
				ready_hold = ((grants_seen / 150) % 3 == 0) ? 0 : $urandom_range(0, 7);
			end else if (ready_hold != 0) begin
				ready_hold--;
			end
			if (s_axis_tvalid && s_axis_tready)
				grants_due.push_back(worst_fit_grant('{cmd: s_axis_tuser,
					size: s_axis_tdata[15:0], idx: s_axis_tdata[19:16]}));
			m_axis_tready <= (ready_hold == 0);
		end
	end

	task automatic queue_cmd(input logic cmd, input logic [REQ_W-1:0] size,
			input logic [BIDX_W-1:0] idx, input bit drain);
		queued_cmd_t q;
		q.op = '{cmd: cmd, size: size, idx: idx};
		q.gap = ((queued_total / 150) % 3 == 1) ? 0 : $urandom_range(0, 7);
		q.drain = drain;
		alloc_cmds.push_back(q);
		queued_total++;
	endtask

	initial begin
		logic [REQ_W-1:0] fill_sizes [12];
		logic [REQ_W-1:0] sz;
		int               pick;
		fill_sizes = '{16'h8000, 16'h0001, 16'h00FF, 16'h8000, 16'h1234, 16'h0100,
			16'hFFFE, 16'h0001, 16'h4000, 16'h00FF, 16'h7FFF, 16'h0010};

		// Releases on an empty table are refused.
		queue_cmd(CMD_RELEASE, 16'hFFFF, 4'd0, 1'b0);
		queue_cmd(CMD_RELEASE, 16'h0000, 4'd15, 1'b0);
		// Appends, including a zero-size block and the largest size.
		queue_cmd(CMD_ALLOC, 16'h0000, 4'd15, 1'b0);
		queue_cmd(CMD_ALLOC, 16'hFFFF, 4'd0, 1'b0);
		queue_cmd(CMD_ALLOC, 16'd100, 4'd7, 1'b0);
		queue_cmd(CMD_ALLOC, 16'd100, 4'd8, 1'b0);
		// Release, then a second release of the same block, then releases of blocks 2 and 3.
		queue_cmd(CMD_RELEASE, 16'h0000, 4'd1, 1'b0);
		queue_cmd(CMD_RELEASE, 16'hFFFF, 4'd1, 1'b0);
		queue_cmd(CMD_RELEASE, 16'h5555, 4'd2, 1'b0);
		queue_cmd(CMD_RELEASE, 16'hAAAA, 4'd3, 1'b0);
		// Worst fit takes the largest block, then the lower index of two equal ones.
		queue_cmd(CMD_ALLOC, 16'd50, 4'd5, 1'b0);
		queue_cmd(CMD_ALLOC, 16'd50, 4'd10, 1'b0);
		// A zero request fits any free block.
		queue_cmd(CMD_ALLOC, 16'h0000, 4'd0, 1'b0);
		// Index beyond the blocks created so far.
		queue_cmd(CMD_RELEASE, 16'h0000, 4'd5, 1'b0);
		for (int i = 0; i < 12; i++)
			queue_cmd(CMD_ALLOC, fill_sizes[i], BIDX_W'(i), 1'b0);
		// Table full and nothing free: the allocation fails.
		queue_cmd(CMD_ALLOC, 16'hFFFF, 4'd9, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 7);
			case (pick)
				0: sz = 16'h0000;
				1: sz = 16'hFFFF;
				2, 3: sz = REQ_W'($urandom_range(0, 255));
				default: sz = REQ_W'($urandom);
			endcase
			queue_cmd($urandom_range(0, 1) ? CMD_RELEASE : CMD_ALLOC, sz,
				BIDX_W'($urandom_range(0, 15)), (n % 400) == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (alloc_cmds.size() != 0 || s_axis_tvalid || grants_due.size() != 0);
		repeat (NUM_BLOCKS + 8) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
